/* design/olar_pkg.sv */
// ----------------------------------------------------------------------------
// olar_pkg
// Shared constants, codes and handshake types for the ordered list block.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int OLAR_DEPTH = 64;
  localparam int ACT_W      = 2;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 8;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 7;

  typedef logic        [ACT_W-1:0]  action_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic        [POS_W-1:0]  pos_t;
  typedef logic        [STAT_W-1:0] status_t;
  typedef logic        [CNT_W-1:0]  count_t;

  // actions
  localparam action_t ACT_APPEND   = 2'd0;
  localparam action_t ACT_REM_HEAD = 2'd1;
  localparam action_t ACT_REM_TAIL = 2'd2;
  localparam action_t ACT_REM_POS  = 2'd3;

  // result status
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic capture;
    logic shift;
    logic dec;
    logic load_out;
  } olar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rm_go;
    logic more_rd;
    logic more_sh;
    logic out_free;
  } olar_st_t;

endpackage

/* design/olar_if.sv */
// ----------------------------------------------------------------------------
// olar_in_if / olar_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface olar_in_if import olar_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  word_t   value;
  pos_t    position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface olar_out_if import olar_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   removed_value;
  count_t  entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input entry_count,
                  output ready);
endinterface

/* design/olar_ram.sv */
// ----------------------------------------------------------------------------
// olar_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module olar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* design/olar_ctrl.sv */
// ----------------------------------------------------------------------------
// olar_ctrl
// Sequencer for one request: evaluate, read the removed word, shift the tail, load the result.
// ----------------------------------------------------------------------------
module olar_ctrl import olar_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  olar_st_t  st,
  output olar_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_SH   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = st.rm_go ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd.capture = 1'b1;
        if (st.more_rd) begin
          state_nxt = S_SH;
        end else begin
          cmd.dec   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SH: begin
        cmd.shift = 1'b1;
        if (!st.more_sh) begin
          cmd.dec   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/olar_dp.sv */
// ----------------------------------------------------------------------------
// olar_dp
// List storage, count, shift pointer and result register.
// ----------------------------------------------------------------------------
module olar_dp import olar_pkg::*; #(
  parameter int DEPTH = OLAR_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  action_t   in_action,
  input  word_t     in_value,
  input  pos_t      in_position,
  input  olar_cmd_t cmd,
  output olar_st_t  st,
  input  logic      out_ready,
  output logic      out_valid,
  output status_t   out_status,
  output word_t     out_removed_value,
  output count_t    out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [AW-1:0] dst_r;
  action_t       act_r;
  word_t         val_r;
  pos_t          pos_r;
  status_t       stat_r;
  word_t         rem_r;
  logic          out_valid_r;
  status_t       out_stat_r;
  word_t         out_rem_r;
  count_t        out_cnt_r;

  status_t       ev_stat;
  logic [AW-1:0] ev_idx;
  logic          app_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // request evaluation
  always_comb begin
    ev_stat = ST_OK;
    if (act_r == ACT_APPEND) begin
      if (count_r >= CW'(DEPTH)) ev_stat = ST_FULL;
    end else if (count_r == '0) begin
      ev_stat = ST_EMPTY;
    end else if (act_r == ACT_REM_POS &&
                 {{CW{1'b0}}, pos_r} >= {{POS_W{1'b0}}, count_r}) begin
      ev_stat = ST_NOTFOUND;
    end
  end

  always_comb begin
    case (act_r)
      ACT_REM_HEAD: ev_idx = '0;
      ACT_REM_TAIL: ev_idx = AW'(count_r - CW'(1));
      default:      ev_idx = AW'(pos_r);
    endcase
  end

  assign app_ok     = (act_r == ACT_APPEND) && (ev_stat == ST_OK);
  assign st.rm_go   = (act_r != ACT_APPEND) && (ev_stat == ST_OK);
  assign st.more_rd = ((CW+1)'(dst_r) + (CW+1)'(1)) < (CW+1)'(count_r);
  assign st.more_sh = ((CW+1)'(dst_r) + (CW+1)'(2)) < (CW+1)'(count_r);
  assign st.out_free = !out_valid_r || out_ready;

  // storage ports
  assign ram_we    = (cmd.eval && app_ok) || cmd.shift;
  assign ram_waddr = cmd.shift ? dst_r : AW'(count_r);
  assign ram_wdata = cmd.shift ? ram_rdata : val_r;
  assign ram_raddr = cmd.eval  ? ev_idx :
                     cmd.shift ? dst_r + AW'(2) : dst_r + AW'(1);

  olar_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.eval) begin
      stat_r <= ev_stat;
      rem_r  <= '0;
      dst_r  <= ev_idx;
    end
    if (cmd.capture) begin
      rem_r <= ram_rdata;
    end
    if (cmd.shift) begin
      dst_r <= dst_r + AW'(1);
    end
    if (cmd.load_out) begin
      out_stat_r <= stat_r;
      out_rem_r  <= rem_r;
      out_cnt_r  <= CNT_W'(count_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval && app_ok) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_stat_r;
  assign out_removed_value = out_rem_r;
  assign out_entry_count   = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("word count above depth");

  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> ((CW+1)'(dst_r) + (CW+1)'(1)) < (CW+1)'(count_r))
    else $error("shift outside held words");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec |-> count_r != '0)
    else $error("removal from empty list");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && app_ok) |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not bump count");

endmodule

/* design/ordered_list_append_remove.sv */
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Bounded ordered list of signed words with append and indexed removal.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result word. An append, and any
// request that ends in a full, empty or not-found status, goes through S_EVAL
// and S_FIN. A successful removal at index i with n words held goes through
// S_EVAL, S_RD, one S_SH step for each of the n - i - 1 words behind the
// removed one, and S_FIN: those words move up one place per cycle through the
// single read port of the list memory. A finished result waits in an output
// register, and the next request is taken while it waits.
module ordered_list_append_remove import olar_pkg::*; #(
  parameter int DEPTH = OLAR_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  olar_in_if.sink   in_if,
  olar_out_if.source out_if
);

  olar_cmd_t cmd;
  olar_st_t  st;

  olar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  olar_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_if.action),
    .in_value          (in_if.value),
    .in_position       (in_if.position),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_status        (out_if.status),
    .out_removed_value (out_if.removed_value),
    .out_entry_count   (out_if.entry_count)
  );

endmodule
